/* sv/dense_layer_relu_unit_defines.svh */
// Assertion macros for the dense layer controller.
// Each macro expects clk and arst_n in scope; no other dependencies.
`ifndef DENSE_LAYER_RELU_UNIT_DEFINES_SVH
`define DENSE_LAYER_RELU_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DLR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DLR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/dlr_pkg.sv */
// Shared types and constants for the dense layer with ReLU.
// No dependencies; imported by the datapath, controller and top level, not by dlr_ram.
package dlr_pkg;

	// Default sizes of the layer.
	localparam int NUM_IN_DEF  = 256;
	localparam int NUM_OUT_DEF = 16;

	// Fixed field and datapath widths.
	localparam int KIND_W    = 2;
	localparam int IN_IDX_W  = 8;
	localparam int OUT_IDX_W = 4;
	localparam int VAL_W     = 16;
	localparam int PROD_W    = 32;
	localparam int ACC_W     = 40;
	localparam int SUM_W     = 41;
	localparam int ACT_W     = 15;
	localparam int NEURON_W  = 4;
	localparam int CFG_W     = 5;
	localparam int EMIT_MAX  = 16;

	// Reset values of the configuration registers.
	localparam logic [CFG_W-1:0] SHIFT_RST  = 5'd8;
	localparam logic [CFG_W-1:0] ACTIVE_RST = 5'd16;

	// Register index, taken from paddr[2].
	localparam logic REG_SHIFT  = 1'b0;
	localparam logic REG_ACTIVE = 1'b1;

	// Input item kinds carried on tuser.
	typedef enum logic [KIND_W-1:0] {
		KIND_WEIGHT  = 2'd0,
		KIND_BIAS    = 2'd1,
		KIND_FEATURE = 2'd2
	} dlr_kind_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic                take;
		logic                mul;
		logic                acc;
		logic                bias_rd;
		logic                sum;
		logic                load_out;
		logic                row_end;
		logic                clear;
		logic [NEURON_W-1:0] neuron;
	} dlr_cmd_t;

endpackage

/* sv/dlr_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module dlr_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

/* sv/dlr_datapath.sv */
// Datapath of the dense layer: weight and bias stores, parallel MAC lanes,
// accumulators, output scaling and the result register. Uses dlr_pkg, dlr_ram.
module dlr_datapath #(
	parameter int NUM_IN  = dlr_pkg::NUM_IN_DEF,
	parameter int NUM_OUT = dlr_pkg::NUM_OUT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  dlr_pkg::dlr_cmd_t             cmd,
	input  logic [dlr_pkg::KIND_W-1:0]    kind,
	input  logic [dlr_pkg::IN_IDX_W-1:0]  in_index,
	input  logic [dlr_pkg::OUT_IDX_W-1:0] out_index,
	input  logic [dlr_pkg::VAL_W-1:0]     value,
	input  logic [dlr_pkg::CFG_W-1:0]     result_shift,
	input  logic                          out_ready,
	output logic                          out_free,
	output logic                          out_valid,
	output logic [dlr_pkg::NEURON_W-1:0]  out_neuron,
	output logic [dlr_pkg::ACT_W-1:0]     out_act,
	output logic                          out_row_end
);
	import dlr_pkg::*;

	localparam int IW = $clog2(NUM_IN);
	localparam int CW = $clog2(NUM_IN + 1);
	localparam int OW = (NUM_OUT > 1) ? $clog2(NUM_OUT) : 1;

	logic                     wr_weight;
	logic                     wr_bias;
	logic                     rd_weight;
	logic [CW-1:0]            cnt_q;
	logic                     ok_q;
	logic signed [VAL_W-1:0]  val_q;
	logic [VAL_W-1:0]         w_rd   [NUM_OUT];
	logic signed [PROD_W-1:0] prod_q [NUM_OUT];
	logic [ACC_W-1:0]         acc_q  [NUM_OUT];
	logic [VAL_W-1:0]         bias_rd;
	logic [OW-1:0]            sel;
	logic [ACC_W-1:0]         acc_sel;
	logic [SUM_W-1:0]         sum_d;
	logic [SUM_W-1:0]         sum_q;
	logic                     sum_pos;
	logic [ACC_W-1:0]         shifted;
	logic [ACT_W-1:0]         act_d;
	logic                     out_valid_q;
	logic [NEURON_W-1:0]      out_neuron_q;
	logic [ACT_W-1:0]         out_act_q;
	logic                     out_row_end_q;

	// Decode accepted items into store writes and a weight row read.
	assign wr_weight = cmd.take && (kind == KIND_WEIGHT) &&
		(32'(in_index) < NUM_IN) && (32'(out_index) < NUM_OUT);
	assign wr_bias   = cmd.take && (kind == KIND_BIAS) && (32'(out_index) < NUM_OUT);
	assign rd_weight = cmd.take && (kind == KIND_FEATURE);

	// One weight column per lane, all read at the current feature row.
	for (genvar o = 0; o < NUM_OUT; o++) begin : g_lane
		dlr_ram #(
			.WIDTH(VAL_W),
			.DEPTH(NUM_IN),
			.AW   (IW)
		) u_weight_ram (
			.clk    (clk),
			.wr_en  (wr_weight && (32'(out_index) == o)),
			.wr_addr(IW'(in_index)),
			.wr_data(value),
			.rd_en  (rd_weight),
			.rd_addr(IW'(cnt_q)),
			.rd_data(w_rd[o])
		);

		// Multiply stage.
		always_ff @(posedge clk) begin
			if (cmd.mul) begin
				prod_q[o] <= $signed(w_rd[o]) * val_q;
			end
		end

		// Accumulate stage; wraps in 40 bits.
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				acc_q[o] <= '0;
			end else if (cmd.clear) begin
				acc_q[o] <= '0;
			end else if (cmd.acc && ok_q) begin
				acc_q[o] <= acc_q[o] + {{(ACC_W-PROD_W){prod_q[o][PROD_W-1]}}, prod_q[o]};
			end
		end
	end

	// Bias store, read once per emitted neuron.
	dlr_ram #(
		.WIDTH(VAL_W),
		.DEPTH(NUM_OUT),
		.AW   (OW)
	) u_bias_ram (
		.clk    (clk),
		.wr_en  (wr_bias),
		.wr_addr(OW'(out_index)),
		.wr_data(value),
		.rd_en  (cmd.bias_rd),
		.rd_addr(sel),
		.rd_data(bias_rd)
	);

	// Feature value and in-range flag captured at acceptance.
	always_ff @(posedge clk) begin
		if (rd_weight) begin
			val_q <= $signed(value);
		end
	end

	// Feature counter stops at NUM_IN and clears at the end of a row.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			ok_q  <= 1'b0;
		end else begin
			if (rd_weight) begin
				ok_q <= (cnt_q < CW'(NUM_IN));
			end
			if (cmd.clear) begin
				cnt_q <= '0;
			end else if (cmd.acc && ok_q) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// Biased sum of the selected neuron, bias scaled to Q16.16.
	assign sel     = OW'(cmd.neuron);
	assign acc_sel = acc_q[sel];
	assign sum_d   = {acc_sel[ACC_W-1], acc_sel} +
		{{(SUM_W-VAL_W-8){bias_rd[VAL_W-1]}}, bias_rd, 8'd0};

	always_ff @(posedge clk) begin
		if (cmd.sum) begin
			sum_q <= sum_d;
		end
	end

	// Shift, ReLU and saturation.
	assign sum_pos = !sum_q[SUM_W-1] && (|sum_q);
	assign shifted = sum_q[ACC_W-1:0] >> result_shift;
	assign act_d   = !sum_pos ? '0 :
		((|shifted[ACC_W-1:ACT_W]) ? {ACT_W{1'b1}} : shifted[ACT_W-1:0]);

	// Result register toward the output channel.
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_neuron_q  <= cmd.neuron;
			out_act_q     <= act_d;
			out_row_end_q <= cmd.row_end;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_neuron  = out_neuron_q;
	assign out_act     = out_act_q;
	assign out_row_end = out_row_end_q;

endmodule

/* sv/dlr_ctrl.sv */
// Controller of the dense layer: sequences the MAC of each feature and the
// per-neuron emission at the end of a row. Uses dlr_pkg and the assertion macros.
`include "dense_layer_relu_unit_defines.svh"

module dlr_ctrl #(
	parameter int NUM_OUT = dlr_pkg::NUM_OUT_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic [dlr_pkg::KIND_W-1:0]  kind,
	input  logic                        in_last,
	input  logic [dlr_pkg::CFG_W-1:0]   active_outputs,
	input  logic                        out_free,
	output logic                        in_ready,
	output dlr_pkg::dlr_cmd_t           cmd
);
	import dlr_pkg::*;

	localparam int LIM = (NUM_OUT < EMIT_MAX) ? NUM_OUT : EMIT_MAX;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_MUL  = 6'b000010,
		S_ACC  = 6'b000100,
		S_BRD  = 6'b001000,
		S_SUM  = 6'b010000,
		S_OUT  = 6'b100000
	} dlr_state_t;

	dlr_state_t          state_q;
	dlr_state_t          state_d;
	logic                last_q;
	logic [NEURON_W-1:0] idx_q;
	logic [CFG_W-1:0]    emit_n;
	logic [NEURON_W-1:0] last_idx;
	logic                at_last;

	// Number of neurons emitted per row, clamped to one and to the limit.
	always_comb begin
		if (active_outputs == '0) begin
			emit_n = CFG_W'(1);
		end else if (active_outputs > CFG_W'(LIM)) begin
			emit_n = CFG_W'(LIM);
		end else begin
			emit_n = active_outputs;
		end
	end

	assign last_idx = NEURON_W'(emit_n - 1'b1);
	assign at_last  = (idx_q == last_idx);
	assign in_ready = (state_q == S_IDLE);

	// Next state and command decode.
	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		cmd.take     = in_valid && in_ready;
		cmd.neuron   = idx_q;
		cmd.row_end  = at_last;
		case (state_q)
			S_IDLE: begin
				if (in_valid && (kind == KIND_FEATURE)) begin
					state_d = S_MUL;
				end
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_ACC;
			end
			S_ACC: begin
				cmd.acc = 1'b1;
				state_d = last_q ? S_BRD : S_IDLE;
			end
			S_BRD: begin
				cmd.bias_rd = 1'b1;
				state_d     = S_SUM;
			end
			S_SUM: begin
				cmd.sum = 1'b1;
				state_d = S_OUT;
			end
			S_OUT: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					if (at_last) begin
						cmd.clear = 1'b1;
						state_d   = S_IDLE;
					end else begin
						state_d = S_BRD;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State, row-end flag and neuron index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			last_q  <= 1'b0;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.take) begin
				last_q <= in_last;
			end
			if (state_q == S_ACC) begin
				idx_q <= '0;
			end else if (cmd.load_out) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	// A result is loaded only when the output register can take it.
	`DLR_ASSERT_NOW(a_load_free, cmd.load_out, out_free, "result loaded into a busy output register")
	// An accepted feature goes straight to the multiply step.
	`DLR_ASSERT_NEXT(a_feat_mul, cmd.take && (kind == KIND_FEATURE), state_q == S_MUL, "feature did not start its multiply")
	// Accumulators clear only together with the last result of a row.
	`DLR_ASSERT_NOW(a_clear_end, cmd.clear, cmd.row_end && cmd.load_out, "accumulators cleared before the row ended")
	// A feature that does not end its row returns to idle after accumulating.
	`DLR_ASSERT_NEXT(a_acc_idle, (state_q == S_ACC) && !last_q, state_q == S_IDLE, "non-final feature did not return to idle")

endmodule

/* sv/dense_layer_relu_unit.sv */
// Weight and bias writes are accepted while idle; a feature passes through row read, multiply
// and accumulate across all NUM_OUT lanes in parallel, and no new item is taken until it is done.
// A feature that ends a row then adds bias read, biased sum and scale steps per emitted neuron,
// plus any output stall; its first result follows the multiply, accumulate, bias read and sum steps.
// Reset is asynchronous, active low: accumulators and feature counter clear, shift is 8,
// active outputs is 16; weight and bias stores hold no defined value until written.
module dense_layer_relu_unit #(
	parameter int NUM_IN  = dlr_pkg::NUM_IN_DEF,
	parameter int NUM_OUT = dlr_pkg::NUM_OUT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// Input stream.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // in_index[7:0], out_index[11:8], value[27:12], zero[31:28]
	input  logic [1:0]  s_tuser,  // kind[1:0]
	input  logic        s_tlast,
	// Result stream.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // neuron[3:0], activation[18:4], zero[23:19]
	output logic        m_tlast,
	// Configuration port.
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import dlr_pkg::*;

	logic [CFG_W-1:0]    result_shift_q;
	logic [CFG_W-1:0]    active_outputs_q;
	logic                cfg_wr;
	dlr_cmd_t            cmd;
	logic                out_free;
	logic [NEURON_W-1:0] out_neuron;
	logic [ACT_W-1:0]    out_act;

	// Configuration registers; the register index is paddr[2].
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_shift_q   <= SHIFT_RST;
			active_outputs_q <= ACTIVE_RST;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_SHIFT) begin
				result_shift_q <= pwdata[CFG_W-1:0];
			end else begin
				active_outputs_q <= pwdata[CFG_W-1:0];
			end
		end
	end

	assign prdata = (paddr[2] == REG_ACTIVE) ? 32'(active_outputs_q) : 32'(result_shift_q);

	dlr_ctrl #(
		.NUM_OUT(NUM_OUT)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (s_tvalid),
		.kind          (s_tuser),
		.in_last       (s_tlast),
		.active_outputs(active_outputs_q),
		.out_free      (out_free),
		.in_ready      (s_tready),
		.cmd           (cmd)
	);

	dlr_datapath #(
		.NUM_IN (NUM_IN),
		.NUM_OUT(NUM_OUT)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.kind        (s_tuser),
		.in_index    (s_tdata[7:0]),
		.out_index   (s_tdata[11:8]),
		.value       (s_tdata[27:12]),
		.result_shift(result_shift_q),
		.out_ready   (m_tready),
		.out_free    (out_free),
		.out_valid   (m_tvalid),
		.out_neuron  (out_neuron),
		.out_act     (out_act),
		.out_row_end (m_tlast)
	);

	// Pack the result fields, lowest field first.
	assign m_tdata = {5'd0, out_act, out_neuron};

endmodule
